[hw/rtl/tsar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tsar_pkg;

  localparam int QueueDepth = 4;

  typedef enum logic [1:0] {
    FUNC_LOCAL  = 2'd0,
    FUNC_PEER   = 2'd1,
    FUNC_UPDATE = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_NOST = 3'd1,
    ST_RST  = 3'd2,
    ST_FIN  = 3'd3,
    ST_DUP  = 3'd4,
    ST_REC  = 3'd5,
    ST_CLS  = 3'd6
  } status_t;

  // Status bit positions.
  localparam int B_HAVE_ACK      = 0;
  localparam int B_DONE_READING  = 1;
  localparam int B_DONE_WRITING  = 2;
  localparam int B_HAVE_PEER_ACK = 3;
  localparam int B_HAVE_PEER_FIN = 4;
  localparam int B_HAVE_FIN      = 5;
  localparam int B_HAVE_PEER_MSS = 6;
  localparam int B_HAVE_PEER_WS  = 7;

  // Result as queued between the state front and the checksum back.
  typedef struct packed {
    logic [2:0]  status;
    logic        closing;
    logic        first_peer_ack;
    logic        ack_changed;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [15:0] csum_in;
    logic        csum_keep;
    logic        patch_ack;
    logic        patch_seq;
    logic [31:0] ack_old;
    logic [31:0] seq_old;
  } work_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        closing;
    logic        first_peer_ack;
    logic        ack_changed;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [15:0] checksum_out;
  } result_t;

  // Fold a 32-bit word into 17 bits.
  function automatic logic [16:0] fold16(input logic [31:0] x);
    fold16 = {1'b0, x[31:16]} + {1'b0, x[15:0]};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/tsar_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module tsar_front import tsar_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_seq_num,
  input  wire logic [31:0] in_ack_num,
  input  wire logic [15:0] in_window,
  input  wire logic [3:0]  in_tcp_flags,
  input  wire logic [15:0] in_checksum,
  input  wire logic [15:0] in_payload_len,
  input  wire logic [2:0]  in_option_flags,
  input  wire logic [15:0] in_mss_value,
  input  wire logic [7:0]  in_ws_value,
  input  wire logic [3:0]  in_update_flags,
  input  wire logic [31:0] in_update_delta,
  output work_t            work
);

  logic [7:0]  bits_r, bits_nxt;
  logic [31:0] off_r, off_nxt, ackv_r, ackv_nxt, raw_r, raw_nxt;
  logic [31:0] lnext_r, lnext_nxt, lfin_r, lfin_nxt, pfin_r, pfin_nxt;
  logic [31:0] pack_r, pack_nxt;
  logic [15:0] pmss_r, pmss_nxt, pwin_r, pwin_nxt, lwin_r, lwin_nxt;
  logic [7:0]  pscale_r, pscale_nxt;

  function automatic logic closing_f(input logic [7:0] b, input logic [31:0] pa,
                                     input logic [31:0] lf, input logic [31:0] pf,
                                     input logic [31:0] av);
    closing_f = b[B_HAVE_ACK] && b[B_HAVE_PEER_ACK] && b[B_HAVE_PEER_FIN] &&
                b[B_HAVE_FIN] && (pa == lf) && (pf == av);
  endfunction

  // Classify the item and compute the next connection state.
  always_comb begin
    logic syn;
    logic [31:0] ln;
    syn = in_tcp_flags[1];
    ln = '0;
    bits_nxt = bits_r; off_nxt = off_r; ackv_nxt = ackv_r; raw_nxt = raw_r;
    lnext_nxt = lnext_r; lfin_nxt = lfin_r; pfin_nxt = pfin_r; pack_nxt = pack_r;
    pmss_nxt = pmss_r; pwin_nxt = pwin_r; lwin_nxt = lwin_r; pscale_nxt = pscale_r;
    work = '0;
    work.status = ST_OK;
    work.seq_out = in_seq_num;
    work.ack_out = in_ack_num;
    work.csum_in = in_checksum;
    work.csum_keep = ~in_option_flags[2];
    work.ack_old = in_ack_num;
    work.seq_old = in_seq_num;
    case (in_func)
      FUNC_PEER: begin
        if (in_option_flags[0]) begin
          pmss_nxt = in_mss_value; bits_nxt[B_HAVE_PEER_MSS] = 1'b1;
        end
        if (in_option_flags[1]) begin
          pscale_nxt = in_ws_value; bits_nxt[B_HAVE_PEER_WS] = 1'b1;
        end
        pwin_nxt = in_window;
        if (syn) begin
          off_nxt = '0; ackv_nxt = in_seq_num + 32'd1; bits_nxt[B_HAVE_ACK] = 1'b1;
        end
        if (in_tcp_flags[0]) begin
          pfin_nxt = in_seq_num + {31'd0, syn} + 32'd1 + {16'd0, in_payload_len};
          bits_nxt[B_HAVE_PEER_FIN] = 1'b1;
        end
        if (in_tcp_flags[3]) begin
          work.first_peer_ack = ~bits_nxt[B_HAVE_PEER_ACK];
          pack_nxt = in_ack_num;
          bits_nxt[B_HAVE_PEER_ACK] = 1'b1;
          if (!bits_nxt[B_HAVE_ACK]) begin
            work.status = ST_NOST;
          end else begin
            work.closing = closing_f(bits_nxt, pack_nxt, lfin_nxt, pfin_nxt, ackv_nxt);
            work.ack_out = in_ack_num + off_nxt;
            work.patch_ack = 1'b1;
          end
        end
      end
      FUNC_LOCAL: begin
        if (in_tcp_flags[2]) begin
          work.status = ST_RST;
        end else begin
          lwin_nxt = in_window;
          ln = in_seq_num + {31'd0, syn} + {16'd0, in_payload_len};
          lnext_nxt = ln;
          if (in_tcp_flags[0] && !bits_r[B_DONE_WRITING]) begin
            work.status = ST_FIN;
          end else begin
            if (in_tcp_flags[0]) begin
              lfin_nxt = ln + 32'd1 - off_r;
              bits_nxt[B_HAVE_FIN] = 1'b1;
            end
            if (!in_tcp_flags[3]) begin
              if (bits_r[B_HAVE_PEER_ACK]) begin
                off_nxt = ln - pack_r;
                bits_nxt[B_DONE_WRITING] = 1'b0;
                work.status = ST_REC;
              end
            end else begin
              raw_nxt = in_ack_num;
              if (bits_r[B_DONE_READING]) begin
                ackv_nxt = in_ack_num;
                bits_nxt[B_HAVE_ACK] = 1'b1;
                work.closing = closing_f(bits_nxt, pack_r, lfin_nxt, pfin_r, ackv_nxt);
                work.seq_out = in_seq_num - off_r;
                work.patch_seq = 1'b1;
              end else if (!bits_r[B_HAVE_ACK]) begin
                work.status = ST_NOST;
              end else if (in_ack_num != ackv_r && in_payload_len == 16'd0) begin
                work.status = ST_DUP;
              end else begin
                if (in_ack_num != ackv_r) begin
                  work.ack_out = ackv_r;
                  work.patch_ack = 1'b1;
                end
                work.seq_out = in_seq_num - off_r;
                work.patch_seq = 1'b1;
              end
            end
          end
        end
      end
      FUNC_UPDATE: begin
        work.seq_out = '0;
        work.ack_out = '0;
        work.csum_keep = 1'b0;
        if (in_update_flags[3]) begin
          work.status = ST_CLS;
        end else begin
          ackv_nxt = (in_update_flags[1] && bits_r[B_HAVE_ACK]) ? raw_r : in_ack_num;
          work.ack_changed = (ackv_nxt != ackv_r);
          pmss_nxt = in_mss_value;
          pscale_nxt = in_ws_value;
          off_nxt = in_update_delta;
          bits_nxt[2:0] = bits_r[2:0] | in_update_flags[2:0];
          work.closing = closing_f(bits_nxt, pack_r, lfin_r, pfin_r, ackv_nxt);
          work.ack_out = ackv_nxt;
        end
      end
      default: begin
        work.csum_keep = 1'b1;
      end
    endcase
  end

  // Connection state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0; off_r <= '0; ackv_r <= '0; raw_r <= '0;
      lnext_r <= '0; lfin_r <= '0; pfin_r <= '0; pack_r <= '0;
      pmss_r <= '0; pwin_r <= '0; lwin_r <= '0; pscale_r <= '0;
    end else if (in_push) begin
      bits_r <= bits_nxt; off_r <= off_nxt; ackv_r <= ackv_nxt; raw_r <= raw_nxt;
      lnext_r <= lnext_nxt; lfin_r <= lfin_nxt; pfin_r <= pfin_nxt; pack_r <= pack_nxt;
      pmss_r <= pmss_nxt; pwin_r <= pwin_nxt; lwin_r <= lwin_nxt; pscale_r <= pscale_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tsar_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module tsar_queue import tsar_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  work_t     wr_data,
  output logic      full,
  input  wire logic rd_en,
  output work_t     rd_data,
  output logic      empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t         mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = (cnt_r == (AW + 1)'(Depth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  // Circular buffer with pointers that wrap at the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW + 1)'(wr_en) - (AW + 1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !rd_en) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> !empty) else $error("count lost a write");

endmodule
`default_nettype wire

[hw/rtl/tsar_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module tsar_back import tsar_pkg::*; (
  input  work_t   work,
  output result_t res
);

  // Incremental one's-complement patch of the checksum.
  always_comb begin
    logic [31:0] sum;
    logic [16:0] f1, f2;
    sum = {16'd0, work.csum_in ^ 16'hffff};
    if (work.patch_ack) begin
      sum = sum + {15'd0, fold16(~work.ack_old)} + {15'd0, fold16(work.ack_out)};
    end
    if (work.patch_seq) begin
      sum = sum + {15'd0, fold16(~work.seq_old)} + {15'd0, fold16(work.seq_out)};
    end
    f1 = fold16(sum);
    f2 = fold16({15'd0, f1});
    res.status         = work.status;
    res.closing        = work.closing;
    res.first_peer_ack = work.first_peer_ack;
    res.ack_changed    = work.ack_changed;
    res.seq_out        = work.seq_out;
    res.ack_out        = work.ack_out;
    if (!work.csum_keep || work.csum_in == 16'd0) begin
      res.checksum_out = '0;
    end else if (work.patch_ack || work.patch_seq) begin
      res.checksum_out = ~f2[15:0];
    end else begin
      res.checksum_out = work.csum_in;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tcp_seq_ack_rewriter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// TCP sequence/acknowledgment rewriter for one connection under recovery.
// Input channel: drive the in_ fields and raise in_push; a request is taken
// on a clock edge where in_push is high and in_full is low.
// Result channel: while out_empty is low the oldest result is on the out_
// ports; raising out_pop takes it on that edge.
// Every request produces exactly one result, in order.
// The front updates connection state combinationally and writes into a
// four-entry queue in the same cycle; the back patches the checksum from the
// queue head combinationally, so each result is registered once, in the queue.
// Throughput is one request per cycle while in_full is low; the next state is
// computed combinationally. When the receiver stops popping, the queue fills
// and in_full rises after four waiting results; state is never lost.
// Synchronous active-low reset clears all connection state and the queue.
module tcp_seq_ack_rewriter_top import tsar_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_seq_num,
  input  wire logic [31:0] in_ack_num,
  input  wire logic [15:0] in_window,
  input  wire logic [3:0]  in_tcp_flags,
  input  wire logic [15:0] in_checksum,
  input  wire logic [15:0] in_payload_len,
  input  wire logic [2:0]  in_option_flags,
  input  wire logic [15:0] in_mss_value,
  input  wire logic [7:0]  in_ws_value,
  input  wire logic [3:0]  in_update_flags,
  input  wire logic [31:0] in_update_delta,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_status,
  output logic             out_closing,
  output logic             out_first_peer_ack,
  output logic             out_ack_changed,
  output logic [31:0]      out_seq_out,
  output logic [31:0]      out_ack_out,
  output logic [15:0]      out_checksum_out
);

  work_t   fwork, qwork;
  result_t res;
  logic    acc, deq;

  assign acc = in_push && !in_full;
  assign deq = out_pop && !out_empty;

  tsar_front u_front (
    .clk, .rst_n, .in_push(acc), .in_func, .in_seq_num, .in_ack_num, .in_window,
    .in_tcp_flags, .in_checksum, .in_payload_len, .in_option_flags, .in_mss_value,
    .in_ws_value, .in_update_flags, .in_update_delta, .work(fwork)
  );

  tsar_queue #(.Depth(Depth)) u_queue (
    .clk, .rst_n, .wr_en(acc), .wr_data(fwork), .full(in_full),
    .rd_en(deq), .rd_data(qwork), .empty(out_empty)
  );

  tsar_back u_back (.work(qwork), .res(res));

  assign out_status         = res.status;
  assign out_closing        = res.closing;
  assign out_first_peer_ack = res.first_peer_ack;
  assign out_ack_changed    = res.ack_changed;
  assign out_seq_out        = res.seq_out;
  assign out_ack_out        = res.ack_out;
  assign out_checksum_out   = res.checksum_out;

endmodule
`default_nettype wire
